### rtl/roitab_pkg.sv
package roitab_pkg;

  typedef logic [2:0] opcode_t;

  localparam opcode_t OP_INSERT = 3'd0;
  localparam opcode_t OP_SET    = 3'd1;
  localparam opcode_t OP_REMOVE = 3'd2;
  localparam opcode_t OP_CHECK  = 3'd3;
  localparam opcode_t OP_READ   = 3'd4;

  typedef logic [1:0] rcode_t;

  localparam rcode_t RC_OK        = 2'd0;
  localparam rcode_t RC_NOT_FOUND = 2'd1;
  localparam rcode_t RC_FULL      = 2'd2;

  localparam int unsigned CoordW = 13;
  localparam int unsigned SizeW  = 12;
  localparam int unsigned AreaW  = 2 * SizeW;
  localparam int unsigned RankW  = 4;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 64;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic        [SizeW-1:0]  w;
    logic        [SizeW-1:0]  h;
  } rect_t;

  typedef struct packed {
    logic             vld;
    opcode_t          op;
    logic [RankW-1:0] rank;
    rect_t            rect;
    logic [AreaW-1:0] q_area;
    logic             done;
    logic             hit;
    logic [SlotW-1:0] slot;
  } tok_t;

endpackage

### rtl/roi_table_overlap_check.sv
// Table of tracked rectangles with rank-addressed access and an overlap check.
// One input beat is one table operation: tuser carries the opcode (insert, set,
// remove, check, read) and tdata the rank and the rectangle. One output beat
// comes back per input beat with the result code, the check verdict, the slot
// touched, the rectangle read and the number of live entries.
// Each slot is a cell in a chain; an operation travels down the chain one cell
// per cycle, so the rank search, the lowest-free search and the overlap scan
// all run as the operation walks the chain. One operation is in flight at a
// time: the next input beat is taken in the cycle after the result is loaded
// into the output register.
// A result that waits on a stalled receiver sits in the output register while
// the next operation is accepted and walks the chain; a second finished result
// waits in a holding register until the first one is taken.
// Reset marks every slot free and clears the live count at once.
module roi_table_overlap_check #(
  parameter int unsigned MAX_OBJECTS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // rank[3:0], rect_x[16:4], rect_y[29:17], rect_w[41:30], rect_h[53:42]
  input  logic [roitab_pkg::InDataW-1:0]  s_axis_tdata,
  // opcode[2:0]
  input  roitab_pkg::opcode_t             s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_code[1:0], overlap_hit[2], slot_used[6:3], out_x[19:7], out_y[32:20],
  // out_w[44:33], out_h[56:45], live_count[61:57]
  output logic [roitab_pkg::OutDataW-1:0] m_axis_tdata
);
  import roitab_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_OBJECTS + 1);

  tok_t tok [MAX_OBJECTS+1];
  logic [MAX_OBJECTS:0] tok_vld;

  tok_t  inj_q;
  logic  busy_q;
  logic  pend_vld_q, out_vld_q;
  logic [OutDataW-1:0] pend_q, out_q, res_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic  accept, load_out;
  rect_t in_rect;
  tok_t  ex;
  rcode_t code;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy_q;
  assign load_out      = pend_vld_q && (!out_vld_q || m_axis_tready);

  assign in_rect.x = s_axis_tdata[16:4];
  assign in_rect.y = s_axis_tdata[29:17];
  assign in_rect.w = s_axis_tdata[41:30];
  assign in_rect.h = s_axis_tdata[53:42];

  assign tok[0] = inj_q;

  for (genvar i = 0; i < MAX_OBJECTS; i++) begin : g_cell
    roitab_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
  end

  for (genvar i = 0; i <= MAX_OBJECTS; i++) begin : g_vld
    assign tok_vld[i] = tok[i].vld;
  end

  assign ex = tok[MAX_OBJECTS];

  always_comb begin
    code  = RC_OK;
    cnt_d = cnt_q;
    res_d = '0;
    case (ex.op) inside
      OP_INSERT: begin
        if (ex.done) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          code = RC_FULL;
        end
      end
      OP_SET, OP_READ: begin
        if (!ex.done) begin
          code = RC_NOT_FOUND;
        end
      end
      OP_REMOVE: begin
        if (!ex.done) begin
          code = RC_NOT_FOUND;
        end else if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: ;
    endcase
    res_d[1:0] = code;
    res_d[2]   = (ex.op == OP_CHECK) && ex.hit;
    if (ex.done) begin
      res_d[6:3] = ex.slot;
    end
    if ((ex.op == OP_READ) && ex.done) begin
      res_d[19:7]  = ex.rect.x;
      res_d[32:20] = ex.rect.y;
      res_d[44:33] = ex.rect.w;
      res_d[56:45] = ex.rect.h;
    end
    res_d[61:57] = 5'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_q      <= '0;
      busy_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      cnt_q      <= '0;
    end else begin
      inj_q.vld <= accept;
      if (accept) begin
        inj_q.op     <= s_axis_tuser;
        inj_q.rank   <= s_axis_tdata[3:0];
        inj_q.rect   <= in_rect;
        inj_q.q_area <= AreaW'(in_rect.w) * AreaW'(in_rect.h);
        inj_q.done   <= 1'b0;
        inj_q.hit    <= 1'b0;
        inj_q.slot   <= '0;
        busy_q       <= 1'b1;
      end else if (load_out) begin
        busy_q <= 1'b0;
      end
      if (ex.vld) begin
        pend_vld_q <= 1'b1;
        cnt_q      <= cnt_d;
      end else if (load_out) begin
        pend_vld_q <= 1'b0;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex.vld) begin
      pend_q <= res_d;
    end
    if (load_out) begin
      out_q <= pend_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one operation in the cell chain");

  a_busy_while_walking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((tok_vld != '0) || pend_vld_q) |-> busy_q)
    else $error("operation in flight while input is open");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_OBJECTS))
    else $error("live count above table size");

  a_accept_launches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> tok_vld[0])
    else $error("accepted beat did not enter the chain");

endmodule

### rtl/roitab_cell.sv
module roitab_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  roitab_pkg::tok_t   tok_i,
  output roitab_pkg::tok_t   tok_o
);
  import roitab_pkg::*;

  logic             ent_vld_q, ent_vld_d;
  rect_t            ent_q;
  logic [AreaW-1:0] area_q;
  logic             wr;
  tok_t             tok_d, tok_q;

  logic signed [CoordW:0]   qxe, qye, exe, eye;
  logic signed [CoordW-1:0] x0, y0;
  logic signed [CoordW:0]   x1, y1;
  logic signed [CoordW+1:0] dx, dy;
  logic                     pos;
  logic [AreaW-1:0]         inter;
  logic                     ovl;

  always_comb begin
    qxe = $signed({tok_i.rect.x[CoordW-1], tok_i.rect.x}) + $signed({2'b00, tok_i.rect.w});
    qye = $signed({tok_i.rect.y[CoordW-1], tok_i.rect.y}) + $signed({2'b00, tok_i.rect.h});
    exe = $signed({ent_q.x[CoordW-1], ent_q.x}) + $signed({2'b00, ent_q.w});
    eye = $signed({ent_q.y[CoordW-1], ent_q.y}) + $signed({2'b00, ent_q.h});
    x0  = (tok_i.rect.x > ent_q.x) ? tok_i.rect.x : ent_q.x;
    y0  = (tok_i.rect.y > ent_q.y) ? tok_i.rect.y : ent_q.y;
    x1  = (qxe < exe) ? qxe : exe;
    y1  = (qye < eye) ? qye : eye;
    dx  = $signed({x1[CoordW], x1}) - $signed({{2{x0[CoordW-1]}}, x0});
    dy  = $signed({y1[CoordW], y1}) - $signed({{2{y0[CoordW-1]}}, y0});
    pos = !dx[CoordW+1] && (dx != '0) && !dy[CoordW+1] && (dy != '0);
    inter = AreaW'(dx[SizeW-1:0]) * AreaW'(dy[SizeW-1:0]);
    ovl = pos && (({inter, 1'b0} > {1'b0, area_q}) || ({inter, 1'b0} > {1'b0, tok_i.q_area}));
  end

  always_comb begin
    tok_d     = tok_i;
    ent_vld_d = ent_vld_q;
    wr        = 1'b0;
    if (tok_i.vld && !tok_i.done) begin
      case (tok_i.op) inside
        OP_INSERT: begin
          if (!ent_vld_q) begin
            wr         = 1'b1;
            ent_vld_d  = 1'b1;
            tok_d.done = 1'b1;
            tok_d.slot = SlotW'(CELL_IDX);
          end
        end
        OP_SET, OP_REMOVE, OP_READ: begin
          if (ent_vld_q) begin
            if (tok_i.rank == '0) begin
              tok_d.done = 1'b1;
              tok_d.slot = SlotW'(CELL_IDX);
              if (tok_i.op == OP_SET) begin
                wr = 1'b1;
              end else if (tok_i.op == OP_REMOVE) begin
                ent_vld_d = 1'b0;
              end else begin
                tok_d.rect = ent_q;
              end
            end else begin
              tok_d.rank = tok_i.rank - 1'b1;
            end
          end
        end
        OP_CHECK: begin
          if (ent_vld_q && ovl) begin
            tok_d.hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
      tok_q     <= '0;
    end else begin
      ent_vld_q <= ent_vld_d;
      tok_q     <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      ent_q  <= tok_i.rect;
      area_q <= AreaW'(tok_i.rect.w) * AreaW'(tok_i.rect.h);
    end
  end

  assign tok_o = tok_q;

endmodule
